[sv/rtrs_pkg.sv]
package rtrs_pkg;

    localparam int STATION_ENTRIES = 64;
    localparam int ARCH_REGS       = 32;
    localparam int VALUE_BITS      = 32;

    localparam int TAG_W     = $clog2(STATION_ENTRIES);
    localparam int REG_IDX_W = $clog2(ARCH_REGS);

    localparam logic [2:0] REQ_ISSUE  = 3'd0;
    localparam logic [2:0] REQ_BCAST  = 3'd1;
    localparam logic [2:0] REQ_SELECT = 3'd2;
    localparam logic [2:0] REQ_REMOVE = 3'd3;
    localparam logic [2:0] REQ_FLUSH  = 3'd4;

    localparam logic [1:0] KIND_REG  = 2'd0;
    localparam logic [1:0] KIND_IMM  = 2'd1;

    typedef struct packed {
        logic [2:0]         req_type;
        logic [1:0]         instr_kind;
        logic               is_branch;
        logic [5:0]         opcode;
        logic [4:0]         src_reg_a;
        logic [4:0]         src_reg_b;
        logic [4:0]         dest_reg;
        logic signed [31:0] immediate;
        logic [5:0]         tag_in;
        logic signed [31:0] result_value;
        logic [4:0]         result_reg;
    } req_t;

    typedef struct packed {
        logic [5:0]         issued_tag;
        logic               stall_res;
        logic               found;
        logic [5:0]         ready_tag;
        logic [5:0]         ready_opcode;
        logic signed [31:0] operand_one;
        logic signed [31:0] operand_two;
        logic signed [31:0] target_address;
        logic [4:0]         ready_dest;
        logic [1:0]         ready_kind;
        logic               reg_updated;
    } rsp_t;

    typedef struct packed {
        logic issue;
        logic rename;
        logic bcast;
        logic select;
        logic remove;
        logic flush;
    } ctl_t;

    typedef struct packed {
        logic                  ok;
        logic [TAG_W-1:0]      tag;
        logic [VALUE_BITS-1:0] val;
    } src_t;

    typedef struct packed {
        logic                  found;
        logic [TAG_W-1:0]      tag;
        logic [5:0]            opcode;
        logic [VALUE_BITS-1:0] op1;
        logic [VALUE_BITS-1:0] op2;
        logic [31:0]           addr;
        logic [4:0]            dest;
        logic [1:0]            kind;
    } sel_t;

    function automatic logic reg_in_range(logic [4:0] r);
        return int'(r) < ARCH_REGS;
    endfunction

    function automatic logic [REG_IDX_W-1:0] reg_idx(logic [4:0] r);
        return REG_IDX_W'(r);
    endfunction

endpackage

[sv/rtrs_regtab.sv]
module rtrs_regtab (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rtrs_pkg::ctl_t               ctl,
    input  rtrs_pkg::req_t               item,
    input  logic [rtrs_pkg::TAG_W-1:0]   issue_tag,
    output rtrs_pkg::src_t               src_a,
    output rtrs_pkg::src_t               src_b,
    output logic                         reg_updated
);

    logic [rtrs_pkg::ARCH_REGS-1:0]                       valid_reg;
    logic [rtrs_pkg::ARCH_REGS-1:0][rtrs_pkg::VALUE_BITS-1:0] value_reg;
    logic [rtrs_pkg::ARCH_REGS-1:0][rtrs_pkg::TAG_W-1:0]  producer_reg;
    logic [rtrs_pkg::VALUE_BITS-1:0]                      rval;

    assign rval = rtrs_pkg::VALUE_BITS'($unsigned(item.result_value));

    function automatic rtrs_pkg::src_t read_src(
        logic [4:0] r,
        logic [rtrs_pkg::ARCH_REGS-1:0] v,
        logic [rtrs_pkg::ARCH_REGS-1:0][rtrs_pkg::VALUE_BITS-1:0] d,
        logic [rtrs_pkg::ARCH_REGS-1:0][rtrs_pkg::TAG_W-1:0] p
    );
        rtrs_pkg::src_t s;
        s = '0;
        if (!rtrs_pkg::reg_in_range(r))
        begin
            s.ok = 1'b1;
        end
        else if (v[rtrs_pkg::reg_idx(r)])
        begin
            s.ok  = 1'b1;
            s.val = d[rtrs_pkg::reg_idx(r)];
        end
        else
        begin
            s.tag = p[rtrs_pkg::reg_idx(r)];
        end
        return s;
    endfunction

    assign src_a = read_src(item.src_reg_a, valid_reg, value_reg, producer_reg);
    assign src_b = read_src(item.src_reg_b, valid_reg, value_reg, producer_reg);

    // validate only if the register still waits on this producer
    assign reg_updated = rtrs_pkg::reg_in_range(item.result_reg)
        && !valid_reg[rtrs_pkg::reg_idx(item.result_reg)]
        && (32'(producer_reg[rtrs_pkg::reg_idx(item.result_reg)]) == 32'(item.tag_in));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '1;
            value_reg    <= '0;
            producer_reg <= '0;
        end
        else if (ctl.flush)
        begin
            valid_reg    <= '1;
            producer_reg <= '0;
        end
        else if (ctl.rename && rtrs_pkg::reg_in_range(item.dest_reg))
        begin
            valid_reg[rtrs_pkg::reg_idx(item.dest_reg)]    <= 1'b0;
            producer_reg[rtrs_pkg::reg_idx(item.dest_reg)] <= issue_tag;
        end
        else if (ctl.bcast && reg_updated)
        begin
            valid_reg[rtrs_pkg::reg_idx(item.result_reg)]    <= 1'b1;
            value_reg[rtrs_pkg::reg_idx(item.result_reg)]    <= rval;
            producer_reg[rtrs_pkg::reg_idx(item.result_reg)] <= '0;
        end
    end

endmodule

[sv/rtrs_station.sv]
module rtrs_station (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rtrs_pkg::ctl_t               ctl,
    input  rtrs_pkg::req_t               item,
    input  rtrs_pkg::src_t               src_a,
    input  rtrs_pkg::src_t               src_b,
    output logic                         full,
    output logic [rtrs_pkg::TAG_W-1:0]   free_tag,
    output rtrs_pkg::sel_t               sel
);

    localparam int N = rtrs_pkg::STATION_ENTRIES;

    logic [N-1:0]                                used_reg;
    logic [N-1:0][5:0]                           opcode_reg;
    logic [N-1:0][4:0]                           dest_reg;
    logic [N-1:0][1:0]                           kind_reg;
    logic [N-1:0][31:0]                          addr_reg;
    rtrs_pkg::src_t [N-1:0][1:0]                 src_reg;
    // older_reg[j][i]: entry j was issued before entry i
    logic [N-1:0][N-1:0]                         older_reg;

    rtrs_pkg::src_t                  new_s0;
    rtrs_pkg::src_t                  new_s1;
    logic [4:0]                      new_dest;
    logic [31:0]                     new_addr;
    logic [rtrs_pkg::VALUE_BITS-1:0] rval;
    logic [N-1:0]                    ready;
    logic [N-1:0]                    pick;

    assign rval = rtrs_pkg::VALUE_BITS'($unsigned(item.result_value));
    assign full = &used_reg;

    always_comb
    begin
        free_tag = '0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_tag = rtrs_pkg::TAG_W'(i);
            end
        end
    end

    always_comb
    begin
        new_s0   = src_a;
        new_s1   = src_b;
        new_dest = 5'd0;
        new_addr = '1;
        if (item.instr_kind == rtrs_pkg::KIND_REG)
        begin
            new_dest = item.dest_reg;
        end
        else if (item.instr_kind == rtrs_pkg::KIND_IMM && !item.is_branch)
        begin
            new_s1.ok  = 1'b1;
            new_s1.tag = '0;
            new_s1.val = rtrs_pkg::VALUE_BITS'($unsigned(item.immediate));
            new_dest   = item.dest_reg;
        end
        else if (item.instr_kind == rtrs_pkg::KIND_IMM)
        begin
            new_addr = item.immediate;
        end
        else
        begin
            new_s0   = '{ok: 1'b1, tag: '0, val: '0};
            new_s1   = '{ok: 1'b1, tag: '0, val: '0};
            new_addr = item.immediate;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (ctl.flush)
        begin
            used_reg <= '0;
        end
        else if (ctl.issue && !full)
        begin
            used_reg[free_tag] <= 1'b1;
        end
        else if (ctl.remove && int'(item.tag_in) < N)
        begin
            used_reg[rtrs_pkg::TAG_W'(item.tag_in)] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue && !full)
        begin
            opcode_reg[free_tag] <= item.opcode;
            kind_reg[free_tag]   <= item.instr_kind;
            dest_reg[free_tag]   <= new_dest;
            addr_reg[free_tag]   <= new_addr;
            src_reg[free_tag][0] <= new_s0;
            src_reg[free_tag][1] <= new_s1;
            for (int j = 0; j < N; j++)
            begin
                older_reg[free_tag][j] <= 1'b0;
                if (rtrs_pkg::TAG_W'(j) != free_tag)
                begin
                    older_reg[j][free_tag] <= 1'b1;
                end
            end
        end
        else if (ctl.bcast)
        begin
            for (int i = 0; i < N; i++)
            begin
                for (int w = 0; w < 2; w++)
                begin
                    if (used_reg[i] && !src_reg[i][w].ok
                        && 32'(src_reg[i][w].tag) == 32'(item.tag_in))
                    begin
                        src_reg[i][w] <= '{ok: 1'b1, tag: '0, val: rval};
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            ready[i] = used_reg[i] && src_reg[i][0].ok && src_reg[i][1].ok;
        end
        for (int i = 0; i < N; i++)
        begin
            logic [N-1:0] col;
            for (int j = 0; j < N; j++)
            begin
                col[j] = older_reg[j][i];
            end
            pick[i] = ready[i] && !(|(ready & col));
        end
    end

    // pick is one-hot or empty: and-or mux
    always_comb
    begin
        sel = '0;
        sel.found = |pick;
        for (int i = 0; i < N; i++)
        begin
            if (pick[i])
            begin
                sel.tag    = sel.tag | rtrs_pkg::TAG_W'(i);
                sel.opcode = sel.opcode | opcode_reg[i];
                sel.op1    = sel.op1 | src_reg[i][0].val;
                sel.op2    = sel.op2 | src_reg[i][1].val;
                sel.addr   = sel.addr | addr_reg[i];
                sel.dest   = sel.dest | dest_reg[i];
                sel.kind   = sel.kind | kind_reg[i];
            end
        end
    end

endmodule

[sv/rename_table_and_reservation_station_unit.sv]
// Tomasulo rename table and reservation station.
// Request channel: req_valid / req_stall with payload req (issue, broadcast,
// select, remove or flush). Response channel: rsp_valid / rsp_stall with
// payload rsp; every request gives exactly one response, in order.
// A request is captured in an input register, processed against the status
// table and station once the output register can take a new response, and
// the response is written to an output register that drives rsp_valid.
// Throughput is one request per cycle while the receiver does not stall;
// the station update, the lowest-free slot search and the oldest-ready pick
// (age matrix) all take effect while the request is processed. When the
// receiver stalls, the response register holds, the pending request waits
// in the input register and req_stall rises until the response is taken.
// Reset: all registers valid with value zero, station empty, no pending
// request or response. Issue into a full station answers stall_res.
module rename_table_and_reservation_station_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_stall,
    input  rtrs_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_stall,
    output rtrs_pkg::rsp_t  rsp
);

    logic                        in_valid_reg;
    rtrs_pkg::req_t              in_item_reg;
    logic                        out_valid_reg;
    rtrs_pkg::rsp_t              out_reg;
    logic                        proc;
    rtrs_pkg::ctl_t              ctl;
    rtrs_pkg::src_t              src_a;
    rtrs_pkg::src_t              src_b;
    logic                        full;
    logic [rtrs_pkg::TAG_W-1:0]  free_tag;
    rtrs_pkg::sel_t              sel;
    logic                        reg_updated;
    rtrs_pkg::rsp_t              result;

    assign proc      = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = in_valid_reg && !proc;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    always_comb
    begin
        ctl        = '0;
        ctl.issue  = proc && in_item_reg.req_type == rtrs_pkg::REQ_ISSUE;
        ctl.bcast  = proc && in_item_reg.req_type == rtrs_pkg::REQ_BCAST;
        ctl.select = proc && in_item_reg.req_type == rtrs_pkg::REQ_SELECT;
        ctl.remove = proc && in_item_reg.req_type == rtrs_pkg::REQ_REMOVE;
        ctl.flush  = proc && in_item_reg.req_type == rtrs_pkg::REQ_FLUSH;
        ctl.rename = ctl.issue && !full
            && (in_item_reg.instr_kind == rtrs_pkg::KIND_REG
                || (in_item_reg.instr_kind == rtrs_pkg::KIND_IMM && !in_item_reg.is_branch));
    end

    rtrs_regtab u_regtab (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .item        (in_item_reg),
        .issue_tag   (free_tag),
        .src_a       (src_a),
        .src_b       (src_b),
        .reg_updated (reg_updated)
    );

    rtrs_station u_station (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .item     (in_item_reg),
        .src_a    (src_a),
        .src_b    (src_b),
        .full     (full),
        .free_tag (free_tag),
        .sel      (sel)
    );

    always_comb
    begin
        result = '0;
        case (in_item_reg.req_type)
            rtrs_pkg::REQ_ISSUE:
            begin
                result.stall_res  = full;
                result.issued_tag = full ? 6'd0 : 6'(free_tag);
            end
            rtrs_pkg::REQ_BCAST:
            begin
                result.reg_updated = reg_updated;
            end
            rtrs_pkg::REQ_SELECT:
            begin
                if (sel.found)
                begin
                    result.found          = 1'b1;
                    result.ready_tag      = 6'(sel.tag);
                    result.ready_opcode   = sel.opcode;
                    result.operand_one    = 32'(sel.op1);
                    result.operand_two    = 32'(sel.op2);
                    result.target_address = sel.addr;
                    result.ready_dest     = sel.dest;
                    result.ready_kind     = sel.kind;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_valid && !req_stall)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_valid && !req_stall)
        begin
            in_item_reg <= req;
        end
        if (proc)
        begin
            out_reg <= result;
        end
    end

endmodule

[dv/tb_rename_table_and_reservation_station_unit.sv]
`timescale 1ns / 1ps

module tb_rename_table_and_reservation_station_unit;

    localparam int N_SLOTS = rtrs_pkg::STATION_ENTRIES;
    localparam int N_REGS = rtrs_pkg::ARCH_REGS;
    localparam int STALL_LIMIT = 20000;
    localparam logic [1:0] KIND_JUMP = 2'd2;
    localparam logic [1:0] KIND_ODD = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    rtrs_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rtrs_pkg::rsp_t rsp;

    int n_errors;
    int idle_cycles;
    bit hold_rx;

    rename_table_and_reservation_station_unit uut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    class station_scoreboard;
        bit          rv[N_REGS];
        logic [31:0] rval[N_REGS];
        logic [5:0]  rprod[N_REGS];
        bit          used[N_SLOTS];
        logic [5:0]  opc[N_SLOTS];
        logic [4:0]  dst[N_SLOTS];
        logic [1:0]  knd[N_SLOTS];
        bit          ok[N_SLOTS][2];
        logic [5:0]  stag[N_SLOTS][2];
        logic [31:0] sval[N_SLOTS][2];
        logic [31:0] addr[N_SLOTS];
        longint      age[N_SLOTS];
        longint      seq;
        rtrs_pkg::rsp_t pending[$];

        function new();
            for (int i = 0; i < N_REGS; i++) begin
                rv[i] = 1;
                rval[i] = 0;
                rprod[i] = 0;
            end
            for (int i = 0; i < N_SLOTS; i++) begin
                used[i] = 0;
                age[i] = 0;
            end
            seq = 0;
        endfunction

        function void read_src(int s, int w, logic [4:0] r);
            if (rv[r]) begin
                ok[s][w] = 1;
                stag[s][w] = 0;
                sval[s][w] = rval[r];
            end else begin
                ok[s][w] = 0;
                stag[s][w] = rprod[r];
                sval[s][w] = 0;
            end
        endfunction

        function void note_request(rtrs_pkg::req_t q);
            rtrs_pkg::rsp_t e;
            int s;
            e = '0;
            case (q.req_type)
                rtrs_pkg::REQ_ISSUE: begin
                    s = -1;
                    for (int i = 0; i < N_SLOTS; i++)
                        if (!used[i] && s < 0) s = i;
                    if (s < 0) e.stall_res = 1;
                    else begin
                        used[s] = 1;
                        opc[s] = q.opcode;
                        knd[s] = q.instr_kind;
                        age[s] = seq++;
                        addr[s] = '1;
                        dst[s] = 0;
                        if (q.instr_kind == rtrs_pkg::KIND_REG) begin
                            read_src(s, 0, q.src_reg_a);
                            read_src(s, 1, q.src_reg_b);
                            dst[s] = q.dest_reg;
                        end else if (q.instr_kind == rtrs_pkg::KIND_IMM && !q.is_branch) begin
                            read_src(s, 0, q.src_reg_a);
                            ok[s][1] = 1;
                            stag[s][1] = 0;
                            sval[s][1] = q.immediate;
                            dst[s] = q.dest_reg;
                        end else if (q.instr_kind == rtrs_pkg::KIND_IMM) begin
                            read_src(s, 0, q.src_reg_a);
                            read_src(s, 1, q.src_reg_b);
                            addr[s] = q.immediate;
                        end else begin
                            for (int w = 0; w < 2; w++) begin
                                ok[s][w] = 1;
                                stag[s][w] = 0;
                                sval[s][w] = 0;
                            end
                            addr[s] = q.immediate;
                        end
                        // sources are read before the rename
                        if (q.instr_kind == rtrs_pkg::KIND_REG ||
                            (q.instr_kind == rtrs_pkg::KIND_IMM && !q.is_branch)) begin
                            rv[q.dest_reg] = 0;
                            rprod[q.dest_reg] = 6'(s);
                        end
                        e.issued_tag = 6'(s);
                    end
                end
                rtrs_pkg::REQ_BCAST: begin
                    for (int i = 0; i < N_SLOTS; i++)
                        if (used[i])
                            for (int w = 0; w < 2; w++)
                                if (!ok[i][w] && stag[i][w] == q.tag_in) begin
                                    ok[i][w] = 1;
                                    stag[i][w] = 0;
                                    sval[i][w] = q.result_value;
                                end
                    if (!rv[q.result_reg] && rprod[q.result_reg] == q.tag_in) begin
                        rv[q.result_reg] = 1;
                        rval[q.result_reg] = q.result_value;
                        rprod[q.result_reg] = 0;
                        e.reg_updated = 1;
                    end
                end
                rtrs_pkg::REQ_SELECT: begin
                    s = -1;
                    for (int i = 0; i < N_SLOTS; i++)
                        if (used[i] && ok[i][0] && ok[i][1] && (s < 0 || age[i] < age[s]))
                            s = i;
                    if (s >= 0) begin
                        e.found = 1;
                        e.ready_tag = 6'(s);
                        e.ready_opcode = opc[s];
                        e.operand_one = sval[s][0];
                        e.operand_two = sval[s][1];
                        e.target_address = addr[s];
                        e.ready_dest = dst[s];
                        e.ready_kind = knd[s];
                    end
                end
                rtrs_pkg::REQ_REMOVE: used[q.tag_in] = 0;
                rtrs_pkg::REQ_FLUSH: begin
                    for (int i = 0; i < N_SLOTS; i++) used[i] = 0;
                    for (int i = 0; i < N_REGS; i++) begin
                        rv[i] = 1;
                        rprod[i] = 0;
                    end
                end
                default: ;
            endcase
            pending.push_back(e);
        endfunction

        task check_response(rtrs_pkg::rsp_t r);
            rtrs_pkg::rsp_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected response", '0, '0);
                return;
            end
            e = pending.pop_front();
            if (r.issued_tag != e.issued_tag)
                report_mismatch("issued_tag", 64'(r.issued_tag), 64'(e.issued_tag));
            if (r.stall_res != e.stall_res)
                report_mismatch("stall_res", 64'(r.stall_res), 64'(e.stall_res));
            if (r.found != e.found)
                report_mismatch("found", 64'(r.found), 64'(e.found));
            if (r.ready_tag != e.ready_tag)
                report_mismatch("ready_tag", 64'(r.ready_tag), 64'(e.ready_tag));
            if (r.ready_opcode != e.ready_opcode)
                report_mismatch("ready_opcode", 64'(r.ready_opcode), 64'(e.ready_opcode));
            if (r.operand_one != e.operand_one)
                report_mismatch("operand_one", 64'($unsigned(r.operand_one)),
                                64'($unsigned(e.operand_one)));
            if (r.operand_two != e.operand_two)
                report_mismatch("operand_two", 64'($unsigned(r.operand_two)),
                                64'($unsigned(e.operand_two)));
            if (r.target_address != e.target_address)
                report_mismatch("target_address", 64'($unsigned(r.target_address)),
                                64'($unsigned(e.target_address)));
            if (r.ready_dest != e.ready_dest)
                report_mismatch("ready_dest", 64'(r.ready_dest), 64'(e.ready_dest));
            if (r.ready_kind != e.ready_kind)
                report_mismatch("ready_kind", 64'(r.ready_kind), 64'(e.ready_kind));
            if (r.reg_updated != e.reg_updated)
                report_mismatch("reg_updated", 64'(r.reg_updated), 64'(e.reg_updated));
        endtask
    endclass

    station_scoreboard sb;

    initial begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // monitor: notes transfers on both channels
    always @(posedge clk) begin
        if (rst_n) begin
            if (req_valid && !req_stall) sb.note_request(req);
            if (rsp_valid && !rsp_stall) sb.check_response(rsp);
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge clk) begin
        if (rst_n && idle_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold-off on request
    initial begin
        rsp_stall = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (hold_rx) rsp_stall <= 1;
            else case ($urandom_range(0, 3))
                0: rsp_stall <= ($urandom_range(0, 1) == 0);
                1: rsp_stall <= ($urandom_range(0, 4) == 0);
                default: rsp_stall <= 0;
            endcase
        end
    end

    function automatic rtrs_pkg::req_t random_req();
        rtrs_pkg::req_t q;
        q.req_type = 3'($urandom_range(0, 7));
        q.instr_kind = 2'($urandom_range(0, 3));
        q.is_branch = 1'($urandom_range(0, 1));
        q.opcode = 6'($urandom);
        q.src_reg_a = 5'($urandom);
        q.src_reg_b = 5'($urandom);
        q.dest_reg = 5'($urandom);
        q.immediate = $urandom;
        q.tag_in = 6'($urandom);
        q.result_value = $urandom;
        q.result_reg = 5'($urandom);
        return q;
    endfunction

    // one transfer; hold valid across back-to-back items
    task automatic send_req(input rtrs_pkg::req_t q, input bit keep);
        req_valid <= 1;
        req <= q;
        do @(posedge clk); while (req_stall);
        if (!keep) req_valid <= 0;
    endtask

    task automatic send_gap();
        int g;
        g = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
        for (int i = 0; i < g; i++) @(posedge clk);
    endtask

    // mostly sensible flows: issue, broadcast low tags, select, remove, flush
    function automatic rtrs_pkg::req_t flow_req();
        rtrs_pkg::req_t q;
        int p;
        q = random_req();
        p = $urandom_range(0, 99);
        if (p < 35) q.req_type = rtrs_pkg::REQ_ISSUE;
        else if (p < 60) begin
            q.req_type = rtrs_pkg::REQ_BCAST;
            q.tag_in = 6'($urandom_range(0, 15));
            if (sb.pending.size() % 2 == 0) q.result_reg = 5'($urandom_range(0, 7));
        end else if (p < 80) q.req_type = rtrs_pkg::REQ_SELECT;
        else if (p < 95) begin
            q.req_type = rtrs_pkg::REQ_REMOVE;
            q.tag_in = 6'($urandom_range(0, 15));
        end else if (p < 97) q.req_type = rtrs_pkg::REQ_FLUSH;
        if (q.req_type == rtrs_pkg::REQ_ISSUE && $urandom_range(0, 2) != 0) begin
            q.src_reg_a = 5'($urandom_range(0, 7));
            q.src_reg_b = 5'($urandom_range(0, 7));
            q.dest_reg = 5'($urandom_range(0, 7));
        end
        return q;
    endfunction

    initial begin
        rtrs_pkg::req_t q;
        int burst;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        n_errors = 0;
        idle_cycles = 0;
        hold_rx = 0;
        sb = new();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: every format, extremes, wakeup, select, remove, flush
        q = '0;
        q.req_type = rtrs_pkg::REQ_SELECT;
        send_req(q, 0);
        q = '0; q.req_type = rtrs_pkg::REQ_ISSUE; q.instr_kind = rtrs_pkg::KIND_REG;
        q.opcode = 6'h3f; q.src_reg_a = 0; q.src_reg_b = 31; q.dest_reg = 31;
        send_req(q, 1);
        q.instr_kind = rtrs_pkg::KIND_IMM; q.is_branch = 0; q.src_reg_a = 31; q.dest_reg = 5;
        q.immediate = 32'h8000_0000;
        send_req(q, 1);
        q.is_branch = 1; q.src_reg_a = 5; q.src_reg_b = 31; q.immediate = 32'h7fff_ffff;
        send_req(q, 1);
        q.instr_kind = KIND_JUMP; q.immediate = '1; q.opcode = 0;
        send_req(q, 1);
        q.instr_kind = KIND_ODD; q.immediate = 32'h1234_5678;
        send_req(q, 1);
        q = '0; q.req_type = rtrs_pkg::REQ_SELECT;
        send_req(q, 1);
        q = '0; q.req_type = rtrs_pkg::REQ_BCAST; q.tag_in = 0; q.result_reg = 5;
        q.result_value = 32'h8000_0000;
        send_req(q, 1);
        q.tag_in = 0; q.result_reg = 31; q.result_value = 32'h7fff_ffff;
        send_req(q, 1);
        q.tag_in = 1; q.result_reg = 5; q.result_value = '1;
        send_req(q, 1);
        q = '0; q.req_type = rtrs_pkg::REQ_SELECT;
        send_req(q, 1);
        q = '0; q.req_type = rtrs_pkg::REQ_REMOVE; q.tag_in = 63;
        send_req(q, 1);
        q.tag_in = 3;
        send_req(q, 1);
        q = '0; q.req_type = 3'd5;
        send_req(q, 1);
        q = '1; q.req_type = 3'd7;
        send_req(q, 1);
        q = '0; q.req_type = rtrs_pkg::REQ_FLUSH;
        send_req(q, 0);
        // fill the station past full
        for (int i = 0; i < 66; i++) begin
            q = random_req();
            q.req_type = rtrs_pkg::REQ_ISSUE;
            send_req(q, i < 65);
        end
        q = '0; q.req_type = rtrs_pkg::REQ_SELECT;
        send_req(q, 1);
        q = '0; q.req_type = rtrs_pkg::REQ_FLUSH;
        send_req(q, 0);

        // long receiver hold-off while requests keep coming
        fork
            begin
                hold_rx = 1;
                repeat (40) @(posedge clk);
                hold_rx = 0;
            end
            for (int i = 0; i < 20; i++) send_req(flow_req(), i < 19);
        join

        for (int n = 0; n < 800; ) begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst; i++) begin
                q = ($urandom_range(0, 9) == 0) ? random_req() : flow_req();
                send_req(q, i < burst - 1);
                n++;
            end
            send_gap();
        end
        req_valid <= 0;

        while (sb.pending.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
